// ===== src/ffa_pkg.sv =====
`timescale 1ns / 1ps

package ffa_pkg;

    // Field widths fixed by the port layout
    localparam int ADDR_BITS  = 16;
    localparam int SIZE_W     = 16;
    localparam int LIMIT_W    = ADDR_BITS + 1;
    localparam int TOP_W      = ADDR_BITS + 1;
    localparam int NEED_W     = ADDR_BITS + 2;

    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = LIMIT_W'(65536);
    localparam logic [TOP_W-1:0]   ADDR_SPAN        = TOP_W'(1) << ADDR_BITS;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 16;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NULL    = 2'd1,
        STATUS_NOSPACE = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One block table entry
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [ADDR_BITS-1:0] start;
    } t_entry;

endpackage

// ===== src/ffa_req_if.sv =====
`timescale 1ns / 1ps

interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] request_size;
    logic [15:0] release_address;

    modport source (output valid, output mode, output request_size,
                    output release_address, input ready);
    modport sink   (input valid, input mode, input request_size,
                    input release_address, output ready);
endinterface

// ===== src/ffa_rsp_if.sv =====
`timescale 1ns / 1ps

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_address;
    logic [1:0]  status;

    modport source (output valid, output data_address, output status, input ready);
    modport sink   (input valid, input data_address, input status, output ready);
endinterface

// ===== src/ffa_cfg_if.sv =====
`timescale 1ns / 1ps

interface ffa_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] heap_limit;

    modport source (output valid, output heap_limit, input ready);
    modport sink   (input valid, input heap_limit, output ready);
endinterface

// ===== src/ffa_table.sv =====
`timescale 1ns / 1ps

module ffa_table #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_wr_idx,
    input  ffa_pkg::t_entry               i_wr_entry,
    input  logic [$clog2(MAX_BLOCKS)-1:0] i_rd_idx,
    output ffa_pkg::t_entry               o_rd_entry
);
    import ffa_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_entry;

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[i_rd_idx];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== src/ffa_match.sv =====
`timescale 1ns / 1ps

module ffa_match #(
    parameter int HEADER_BYTES = 16
) (
    input  logic                             i_mode,
    input  logic [ffa_pkg::SIZE_W-1:0]       i_size,
    input  logic [ffa_pkg::ADDR_BITS-1:0]    i_addr,
    input  ffa_pkg::t_entry                  i_entry,
    output logic                             o_hit
);
    import ffa_pkg::*;

    logic [ADDR_BITS:0] data_addr;

    // Data address of the entry under test
    assign data_addr = {1'b0, i_entry.start} + (ADDR_BITS + 1)'(HEADER_BYTES);

    // Alloc: first free block large enough; free: exact data address
    always_comb begin
        if (i_mode == MODE_ALLOC) begin
            o_hit = i_entry.free && (i_entry.size >= i_size);
        end else begin
            o_hit = (data_addr == {1'b0, i_addr});
        end
    end

endmodule

// ===== src/ffa_ctrl.sv =====
`timescale 1ns / 1ps

module ffa_ctrl #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ffa_req_if.sink                       i_req,
    ffa_rsp_if.source                     o_rsp,
    ffa_cfg_if.sink                       i_cfg,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_wr_idx,
    output ffa_pkg::t_entry               o_wr_entry,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_rd_idx,
    input  ffa_pkg::t_entry               i_rd_entry,
    output logic                          o_mode,
    output logic [ffa_pkg::SIZE_W-1:0]    o_size,
    output logic [ffa_pkg::ADDR_BITS-1:0] o_addr,
    input  logic                          i_hit
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    t_state               r_state, n_state;
    logic                 r_mode;
    logic [SIZE_W-1:0]    r_size;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TOP_W-1:0]     r_heap_top, n_heap_top;
    logic [LIMIT_W-1:0]   r_heap_limit;
    logic [ADDR_BITS-1:0] r_res_addr, n_res_addr;
    t_status              r_res_status, n_res_status;
    logic                 r_out_vld, n_out_vld;
    logic [ADDR_BITS-1:0] r_out_addr;
    t_status              r_out_status;

    logic                 req_acc;
    logic                 out_load;
    logic                 null_req;
    logic                 scan_hit;
    logic                 scan_miss;
    logic                 scan_end;
    logic                 tail_hit;
    logic [LIMIT_W-1:0]   limit_eff;
    logic [NEED_W-1:0]    need;
    logic                 no_space;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_mode = r_mode;
    assign o_size = r_size;
    assign o_addr = r_addr;

    // Scan status for the entry read in the previous cycle
    assign null_req  = (r_mode == MODE_ALLOC) ? (r_size == '0) : (r_addr == '0);
    assign scan_hit  = r_chk_vld && i_hit;
    assign scan_miss = !r_chk_vld && (r_rd_idx >= r_count);
    assign scan_end  = null_req || scan_hit || scan_miss;
    assign tail_hit  = (CNT_W'(r_chk_idx) + CNT_W'(1)) == r_count;

    // Append check against the clamped limit
    assign limit_eff = r_heap_limit[LIMIT_W-1] ? ADDR_SPAN : r_heap_limit;
    assign need      = NEED_W'(r_heap_top) + NEED_W'(HEADER_BYTES) + NEED_W'(r_size);
    assign no_space  = (r_count >= CNT_W'(MAX_BLOCKS)) || (need > NEED_W'(limit_eff));

    assign out_load = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Table access, block bookkeeping and result
    always_comb begin
        n_rd_idx     = r_rd_idx;
        n_chk_vld    = 1'b0;
        n_count      = r_count;
        n_heap_top   = r_heap_top;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        o_rd_idx     = r_rd_idx[IDX_W-1:0];
        o_wr_en      = 1'b0;
        o_wr_idx     = r_chk_idx;
        o_wr_entry   = i_rd_entry;
        case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
            end
            S_SCAN: begin
                if (null_req) begin
                    n_res_addr   = '0;
                    n_res_status = STATUS_NULL;
                end else if (scan_hit) begin
                    o_wr_idx = r_chk_idx;
                    if (r_mode == MODE_ALLOC) begin
                        // Reuse the block whole
                        o_wr_en         = 1'b1;
                        o_wr_entry.free = 1'b0;
                        n_res_addr      = ADDR_BITS'({1'b0, i_rd_entry.start}
                                          + (ADDR_BITS + 1)'(HEADER_BYTES));
                    end else if (tail_hit) begin
                        // Drop the last block and lower the heap top
                        n_count    = r_count - CNT_W'(1);
                        n_heap_top = r_heap_top - TOP_W'(HEADER_BYTES)
                                     - TOP_W'(i_rd_entry.size);
                        n_res_addr = '0;
                    end else begin
                        o_wr_en         = 1'b1;
                        o_wr_entry.free = 1'b1;
                        n_res_addr      = '0;
                    end
                    n_res_status = STATUS_OK;
                end else if (scan_miss) begin
                    if (r_mode == MODE_FREE) begin
                        n_res_addr   = '0;
                        n_res_status = STATUS_UNKNOWN;
                    end else if (no_space) begin
                        n_res_addr   = '0;
                        n_res_status = STATUS_NOSPACE;
                    end else begin
                        // Append a new block at the heap top
                        o_wr_en          = 1'b1;
                        o_wr_idx         = r_count[IDX_W-1:0];
                        o_wr_entry.free  = 1'b0;
                        o_wr_entry.size  = r_size;
                        o_wr_entry.start = r_heap_top[ADDR_BITS-1:0];
                        n_count          = r_count + CNT_W'(1);
                        n_heap_top       = need[TOP_W-1:0];
                        n_res_addr       = ADDR_BITS'(r_heap_top + TOP_W'(HEADER_BYTES));
                        n_res_status     = STATUS_OK;
                    end
                end else if (r_rd_idx < r_count) begin
                    // Issue the next read
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_chk_vld = 1'b1;
                end
            end
            S_DONE: begin
                n_rd_idx = '0;
            end
            default: begin
                n_rd_idx = '0;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_idx     <= '0;
            r_chk_vld    <= 1'b0;
            r_count      <= '0;
            r_heap_top   <= '0;
            r_heap_limit <= HEAP_LIMIT_RESET;
            r_out_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_idx   <= n_rd_idx;
            r_chk_vld  <= n_chk_vld;
            r_count    <= n_count;
            r_heap_top <= n_heap_top;
            r_out_vld  <= n_out_vld;
            if (i_cfg.valid) begin
                r_heap_limit <= i_cfg.heap_limit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_mode <= i_req.mode;
            r_size <= i_req.request_size;
            r_addr <= i_req.release_address;
        end
        r_chk_idx    <= r_rd_idx[IDX_W-1:0];
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.data_address = r_out_addr;
    assign o_rsp.status       = r_out_status;

endmodule

// ===== src/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps

// First-fit block allocator. Each request transaction on i_req is an allocate
// or a free; each produces exactly one result transaction on o_rsp with the
// block's data address and a status. The block table lives in a memory with
// one write port and one registered read port that is scanned one entry per
// cycle by one shared compare unit; the scan ends at a null request, at a hit
// or at the end of the table. i_req.ready is high only while no request is in
// progress, and a finished result waits in an output register without holding
// off the next request. The heap_limit register is to be written on i_cfg only
// while the allocator is idle; the block itself does not enforce this. No
// clearing pass is needed after reset.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp,
    ffa_cfg_if.sink   i_cfg
);
    import ffa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    t_entry               wr_entry;
    logic [IDX_W-1:0]     rd_idx;
    t_entry               rd_entry;
    logic                 cur_mode;
    logic [SIZE_W-1:0]    cur_size;
    logic [ADDR_BITS-1:0] cur_addr;
    logic                 hit;

    // Sequencer and bookkeeping
    ffa_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg      (i_cfg),
        .o_wr_en    (wr_en),
        .o_wr_idx   (wr_idx),
        .o_wr_entry (wr_entry),
        .o_rd_idx   (rd_idx),
        .i_rd_entry (rd_entry),
        .o_mode     (cur_mode),
        .o_size     (cur_size),
        .o_addr     (cur_addr),
        .i_hit      (hit)
    );

    // Block table
    ffa_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_idx   (wr_idx),
        .i_wr_entry (wr_entry),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry)
    );

    // Shared entry compare
    ffa_match #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_match (
        .i_mode  (cur_mode),
        .i_size  (cur_size),
        .i_addr  (cur_addr),
        .i_entry (rd_entry),
        .o_hit   (hit)
    );

endmodule

// ===== sim/first_fit_block_allocator_test.sv =====
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
    import ffa_pkg::*;

    localparam int MAX_BLOCKS    = DEF_MAX_BLOCKS;
    localparam int HEADER_BYTES  = DEF_HEADER_BYTES;
    localparam int QUIET_LIMIT   = 2000;
    localparam int FINAL_SETTLE  = MAX_BLOCKS + 4;

    // One request and the result it produces
    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_BITS-1:0] release_address;
    } t_request;

    typedef struct packed {
        logic [ADDR_BITS-1:0] data_address;
        t_status              status;
    } t_reply;

    // Block table and heap registers as the allocator holds them
    typedef struct packed {
        logic [MAX_BLOCKS-1:0][SIZE_W-1:0]    size;
        logic [MAX_BLOCKS-1:0]                free;
        logic [MAX_BLOCKS-1:0][ADDR_BITS-1:0] start;
        logic [7:0]                           count;
        logic [TOP_W-1:0]                     top;
        logic [LIMIT_W-1:0]                   limit;
    } t_heap;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffa_req_if req_bus ();
    ffa_rsp_if rsp_bus ();
    ffa_cfg_if cfg_bus ();

    first_fit_block_allocator #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    // Heap seen by the request generator, and heap tracked at acceptance
    t_heap    issue_heap;
    t_heap    track_heap;
    t_request request_queue[$];
    t_reply   expected_replies[$];
    t_request current_request;
    int       mismatch_count = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       quiet_cycles = 0;
    bit       idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to a heap and produce its result
    task automatic serve_request(inout t_heap h, input t_request r, output t_reply res);
        logic [NEED_W-1:0] need;
        logic [NEED_W-1:0] cap;
        logic [NEED_W-1:0] data_at;
        bit                hit;
        res.data_address = '0;
        res.status       = STATUS_OK;
        hit              = 1'b0;
        if (r.mode == MODE_ALLOC) begin
            if (r.request_size == '0) begin
                res.status = STATUS_NULL;
            end else begin
                // first free block that holds the request, reused whole
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                    if (!hit && i < h.count && h.free[i] && h.size[i] >= r.request_size) begin
                        hit               = 1'b1;
                        h.free[i]         = 1'b0;
                        data_at           = NEED_W'(h.start[i]) + NEED_W'(HEADER_BYTES);
                        res.data_address  = data_at[ADDR_BITS-1:0];
                    end
                end
                if (!hit) begin
                    // append at the heap top if limit and table allow
                    cap  = (h.limit > ADDR_SPAN) ? NEED_W'(ADDR_SPAN) : NEED_W'(h.limit);
                    need = NEED_W'(h.top) + NEED_W'(HEADER_BYTES) + NEED_W'(r.request_size);
                    if (h.count >= MAX_BLOCKS || need > cap) begin
                        res.status = STATUS_NOSPACE;
                    end else begin
                        h.start[h.count] = h.top[ADDR_BITS-1:0];
                        h.size[h.count]  = r.request_size;
                        h.free[h.count]  = 1'b0;
                        h.count          = h.count + 8'd1;
                        data_at          = NEED_W'(h.top) + NEED_W'(HEADER_BYTES);
                        res.data_address = data_at[ADDR_BITS-1:0];
                        h.top            = need[TOP_W-1:0];
                    end
                end
            end
        end else if (r.release_address == '0) begin
            res.status = STATUS_NULL;
        end else begin
            // look up the data address; tail is removed, others marked free
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                data_at = NEED_W'(h.start[i]) + NEED_W'(HEADER_BYTES);
                if (!hit && i < h.count && data_at == NEED_W'(r.release_address)) begin
                    hit = 1'b1;
                    if (i + 1 == h.count) begin
                        h.count = h.count - 8'd1;
                        h.top   = h.top - TOP_W'(HEADER_BYTES) - TOP_W'(h.size[i]);
                    end else begin
                        h.free[i] = 1'b1;
                    end
                end
            end
            if (!hit) res.status = STATUS_UNKNOWN;
        end
    endtask

    task automatic push_request(input logic mode, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_BITS-1:0] addr);
        t_request r;
        t_reply   unused;
        r.mode            = mode;
        r.request_size    = size;
        r.release_address = addr;
        request_queue.push_back(r);
        serve_request(issue_heap, r, unused);
    endtask

    // Mostly well-formed traffic: small allocations and frees of live blocks
    task automatic push_random(input int alloc_pct);
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] addr;
        int                   pick;
        int                   idx;
        size = SIZE_W'($urandom);
        addr = ADDR_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       size = '0;
            else if (pick < 25) size = SIZE_W'($urandom_range(1, 1024));
            else if (pick < 90) size = SIZE_W'($urandom_range(1, 64));
            push_request(MODE_ALLOC, size, addr);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                addr = '0;
            end else if (pick >= 15 && issue_heap.count != 0) begin
                idx  = (pick < 40) ? issue_heap.count - 1 :
                       $urandom_range(0, issue_heap.count - 1);
                addr = issue_heap.start[idx] + ADDR_BITS'(HEADER_BYTES);
                // near miss of a live address
                if (pick >= 92) addr = addr ^ ADDR_BITS'($urandom_range(1, 8));
            end
            push_request(MODE_FREE, size, addr);
        end
    endtask

    // Hold until no request is queued or in flight and every result is back
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        while (request_queue.size() != 0 || req_bus.valid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_heap_limit(input logic [LIMIT_W-1:0] limit);
        wait_idle(2);
        @(posedge i_clk);
        cfg_bus.valid      <= 1'b1;
        cfg_bus.heap_limit <= limit;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid    <= 1'b0;
        issue_heap.limit = limit;
        track_heap.limit = limit;
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int items,
                             input int alloc_pct);
        write_heap_limit(limit);
        @(negedge i_clk);
        repeat (items) push_random(alloc_pct);
    endtask

    // Request driver: present queued requests, with random idle bursts
    always @(posedge i_clk) begin : driver
        t_reply   reply;
        t_request head;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap      = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                serve_request(track_heap, current_request, reply);
                expected_replies.push_back(reply);
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_bus.valid <= 1'b0;
                end else if (request_queue.size() == 0) begin
                    req_bus.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    req_bus.valid <= 1'b0;
                end else begin
                    head                    = request_queue.pop_front();
                    current_request         = head;
                    req_bus.valid           <= 1'b1;
                    req_bus.mode            <= head.mode;
                    req_bus.request_size    <= head.request_size;
                    req_bus.release_address <= head.release_address;
                end
            end
        end
    end

    // Result monitor: compare each result transaction, stall at random
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result: data_address %0d status %0d",
                           rsp_bus.data_address, rsp_bus.status);
                    mismatch_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (rsp_bus.data_address !== want.data_address) begin
                        $error("data_address: expected %0d, actual %0d",
                               want.data_address, rsp_bus.data_address);
                        mismatch_count++;
                    end
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, rsp_bus.status);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.mode            = MODE_ALLOC;
        req_bus.request_size    = '0;
        req_bus.release_address = '0;
        rsp_bus.ready           = 1'b0;
        cfg_bus.valid           = 1'b0;
        cfg_bus.heap_limit      = '0;
        issue_heap              = '0;
        track_heap              = '0;
        issue_heap.limit        = HEAP_LIMIT_RESET;
        track_heap.limit        = HEAP_LIMIT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: null requests, whole-heap block, reuse, tail removal
        write_heap_limit(HEAP_LIMIT_RESET);
        @(negedge i_clk);
        push_request(MODE_ALLOC, 16'd0,     16'hFFFF);
        push_request(MODE_FREE,  16'hFFFF,  16'd0);
        push_request(MODE_FREE,  16'd0,     16'd16);
        push_request(MODE_ALLOC, 16'd65520, 16'd0);
        push_request(MODE_ALLOC, 16'd1,     16'd0);
        push_request(MODE_FREE,  16'd0,     16'd16);
        push_request(MODE_ALLOC, 16'hFFFF,  16'd0);
        push_request(MODE_ALLOC, 16'd100,   16'd0);
        push_request(MODE_ALLOC, 16'd50,    16'd0);
        push_request(MODE_ALLOC, 16'd30,    16'd0);
        push_request(MODE_FREE,  16'd0,     16'd16);
        push_request(MODE_FREE,  16'd0,     16'd16);
        push_request(MODE_ALLOC, 16'd120,   16'd0);
        push_request(MODE_ALLOC, 16'd80,    16'd0);
        push_request(MODE_FREE,  16'd0,     16'd198);
        push_request(MODE_FREE,  16'd0,     16'd244);
        push_request(MODE_FREE,  16'd0,     16'd244);
        push_request(MODE_FREE,  16'd0,     16'd17);
        push_request(MODE_FREE,  16'd0,     16'hFFFF);
        push_request(MODE_ALLOC, 16'd40,    16'd0);
        push_request(MODE_ALLOC, 16'd20,    16'hFFFF);
        push_request(MODE_FREE,  16'd0,     16'd132);

        // Random phases across heap limits, including both extremes
        run_phase(17'h10000, 350, 75);
        run_phase(17'h00000, 100, 45);
        run_phase(17'h1FFFF, 200, 60);
        run_phase(LIMIT_W'($urandom_range(1, 65535)), 150, 65);
        run_phase(17'd2048, 150, 70);
        wait_idle(2);
        idle_on = 1'b0;
        run_phase(17'h0FFFF, 250, 55);

        wait_idle(FINAL_SETTLE);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/ffa_pkg.sv
src/ffa_req_if.sv
src/ffa_rsp_if.sv
src/ffa_cfg_if.sv
src/ffa_table.sv
src/ffa_match.sv
src/ffa_ctrl.sv
src/first_fit_block_allocator.sv
sim/first_fit_block_allocator_test.sv
